FILE: src/hkd_pkg.sv
// shared types and constants for the hkdf-sha256 scalar derivation block
// sha-256 round constants, initial hash, group order, salt, state encoding
// no dependencies
package hkd_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_WAIT,
		ST_RED,
		ST_OUT,
		ST_ERR
	} state_t;

	typedef logic [255:0] word256_t;
	typedef logic [511:0] block_t;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_SIGNER = 2'd1;
	localparam logic [1:0] STAT_LIMIT  = 2'd2;

	localparam logic [1:0] REG_SEED0 = 2'd0;
	localparam logic [1:0] REG_SEED1 = 2'd1;
	localparam logic [1:0] REG_SEED2 = 2'd2;
	localparam logic [1:0] REG_SEED3 = 2'd3;

	// compression sequence: prk over steps 0..3, one counter over steps 4..11
	localparam logic [3:0] STEP_SEED  = 4'd1;
	localparam logic [3:0] STEP_PRK   = 4'd3;
	localparam logic [3:0] STEP_CTR0  = 4'd4;
	localparam logic [3:0] STEP_INFO  = 4'd5;
	localparam logic [3:0] STEP_T1    = 4'd7;
	localparam logic [3:0] STEP_T2IN  = 4'd9;
	localparam logic [3:0] STEP_T2    = 4'd11;

	localparam logic [63:0] LEN_OUTER = 64'd768;
	localparam logic [63:0] LEN_INFO  = 64'd616;
	localparam logic [63:0] LEN_T2IN  = 64'd872;

	localparam logic [143:0] SALT = 144'h6367676d7032312d7072657369676e2d7631;

	localparam word256_t ORDER_N =
		256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;

	localparam word256_t SHA_IV =
		256'h6a09e667bb67ae853c6ef372a54ff53a510e527f9b05688c1f83d9ab5be0cd19;

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] bswap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

FILE: src/hkd_sha_core.sv
// iterative sha-256 compression unit, one round per cycle
// depends on hkd_pkg (round constants, types)
module hkd_sha_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  hkd_pkg::word256_t h_in,
	input  hkd_pkg::block_t   blk,
	output logic              done,
	output hkd_pkg::word256_t digest
);

	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	hkd_pkg::word256_t hin_q;
	logic [5:0] rnd_q;
	logic run_q;
	logic fin_q;

	logic [31:0] s0, s1, w_new, sig1, ch, sig0, maj, t1, t2;

	always_comb begin
		s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
		s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
			^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		sig1 = {e_q[5:0], e_q[31:6]} ^ {e_q[10:0], e_q[31:11]} ^ {e_q[24:0], e_q[31:25]};
		ch = (e_q & f_q) ^ (~e_q & g_q);
		sig0 = {a_q[1:0], a_q[31:2]} ^ {a_q[12:0], a_q[31:13]} ^ {a_q[21:0], a_q[31:22]};
		maj = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
		t1 = h_q + sig1 + ch + hkd_pkg::SHA_K[rnd_q] + w_q[0];
		t2 = sig0 + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			fin_q <= run_q && (rnd_q == 6'd63);
			if (start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hin_q <= h_in;
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= h_in;
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk[511 - 32*i -: 32];
			end
		end else if (run_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			h_q <= g_q;
			g_q <= f_q;
			f_q <= e_q;
			e_q <= d_q + t1;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= a_q;
			a_q <= t1 + t2;
		end
	end

	assign done = fin_q;
	assign digest = {
		hin_q[255:224] + a_q, hin_q[223:192] + b_q, hin_q[191:160] + c_q,
		hin_q[159:128] + d_q, hin_q[127:96] + e_q, hin_q[95:64] + f_q,
		hin_q[63:32] + g_q, hin_q[31:0] + h_q
	};

endmodule

FILE: src/hkdf_sha256_scalar_nonce_derive_top.sv
// Derives a nonce scalar k and a gamma scalar from the configured 256-bit seed, a signer id
// and a slot id through HKDF-SHA256 with the fixed salt, retrying counters until both halves
// reduce to nonzero scalars modulo the secp256k1 order. A request is taken when start is high
// and busy is low; busy stays high until the last result has been shown. Every SHA-256
// compression runs in the shared round unit: the key derivation costs 4 compressions and
// each counter tried costs 8 compressions plus a word-serial order reduction of both
// halves. Once both halves have nonzero scalars, the eight result words (k words 0..3,
// then gamma words 0..3) come out on consecutive cycles.
// Each result is marked by result_valid for exactly one cycle and cannot be held off. A zero
// signer id gives one error item in the cycle right after the request is taken; exceeding
// MAX_TRIES counters gives one error item. The user must write the seed registers through
// wr_en, wr_index and wr_data only while idle; the block itself does not enforce this.
// depends on hkd_pkg and hkd_sha_core
module hkdf_sha256_scalar_nonce_derive_top #(
	parameter int MAX_TRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] signer_number,
	input  logic [31:0] slot_number,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [63:0] wr_data,
	output logic        result_valid,
	output logic [63:0] scalar_word,
	output logic        scalar_select,
	output logic [1:0]  word_position,
	output logic [1:0]  status,
	output logic        last_word
);

	localparam int CTR_W = $clog2(MAX_TRIES + 1);

	hkd_pkg::state_t state_q, state_d;

	logic [63:0] seed_q [4];
	logic [31:0] signer_q, slot_q;
	logic [3:0] step_q;
	logic [CTR_W-1:0] ctr_q;
	logic [2:0] red_cnt_q;
	logic [2:0] out_cnt_q;
	logic borrow_q;
	logic got_k_q, got_g_q;
	logic [1:0] stat_q;
	hkd_pkg::word256_t hash_q, inner_q, prk_q, t1_q, t2_q, diff_q, ks_q, gs_q;

	logic core_start, core_done;
	hkd_pkg::word256_t core_digest, h_in;
	hkd_pkg::block_t blk;
	logic [95:0] info;
	logic [255:0] key_bytes;
	logic [7:0] pad_byte;

	hkd_pkg::word256_t src, chosen;
	logic [63:0] a_word, n_word, d_word;
	logic bin, bout, nz, limit, both;

	hkd_sha_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.h_in   (h_in),
		.blk    (blk),
		.done   (core_done),
		.digest (core_digest)
	);

	// block and chaining value for the current compression step
	always_comb begin
		info = {hkd_pkg::bswap32(signer_q), hkd_pkg::bswap32(slot_q),
			hkd_pkg::bswap32({{(32-CTR_W){1'b0}}, ctr_q})};
		key_bytes = (step_q < hkd_pkg::STEP_CTR0) ? {hkd_pkg::SALT, 112'b0} : prk_q;
		pad_byte = step_q[1] ? 8'h5c : 8'h36;
		h_in = step_q[0] ? hash_q : hkd_pkg::SHA_IV;
		if (!step_q[0]) begin
			blk = {key_bytes, 256'b0} ^ {64{pad_byte}};
		end else if (step_q == hkd_pkg::STEP_SEED) begin
			blk = {seed_q[0], seed_q[1], seed_q[2], seed_q[3], 8'h80, 184'b0,
				hkd_pkg::LEN_OUTER};
		end else if (step_q == hkd_pkg::STEP_INFO) begin
			blk = {info, 8'h01, 8'h80, 336'b0, hkd_pkg::LEN_INFO};
		end else if (step_q == hkd_pkg::STEP_T2IN) begin
			blk = {t1_q, info, 8'h02, 8'h80, 80'b0, hkd_pkg::LEN_T2IN};
		end else begin
			blk = {inner_q, 8'h80, 184'b0, hkd_pkg::LEN_OUTER};
		end
	end

	// word-serial compare and subtract of the group order, least significant word first
	always_comb begin
		src = red_cnt_q[2] ? t2_q : t1_q;
		a_word = src[64*red_cnt_q[1:0] +: 64];
		n_word = hkd_pkg::ORDER_N[64*red_cnt_q[1:0] +: 64];
		bin = (red_cnt_q[1:0] == 2'd0) ? 1'b0 : borrow_q;
		{bout, d_word} = {1'b0, a_word} - {1'b0, n_word} - {64'b0, bin};
		chosen = bout ? src : {d_word, diff_q[255:64]};
		nz = |chosen;
		limit = ({1'b0, ctr_q} + {{CTR_W{1'b0}}, 1'b1}) > (CTR_W+1)'(MAX_TRIES);
		both = got_k_q && (got_g_q || nz);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hkd_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (signer_number == 32'd0) ? hkd_pkg::ST_ERR : hkd_pkg::ST_HASH;
				end
			end
			hkd_pkg::ST_HASH: state_d = hkd_pkg::ST_WAIT;
			hkd_pkg::ST_WAIT: begin
				if (core_done) begin
					state_d = (step_q == hkd_pkg::STEP_T2) ? hkd_pkg::ST_RED : hkd_pkg::ST_HASH;
				end
			end
			hkd_pkg::ST_RED: begin
				if (red_cnt_q == 3'd7) begin
					if (limit) begin
						state_d = hkd_pkg::ST_ERR;
					end else if (both) begin
						state_d = hkd_pkg::ST_OUT;
					end else begin
						state_d = hkd_pkg::ST_HASH;
					end
				end
			end
			hkd_pkg::ST_OUT: begin
				if (out_cnt_q == 3'd7) begin
					state_d = hkd_pkg::ST_IDLE;
				end
			end
			hkd_pkg::ST_ERR: state_d = hkd_pkg::ST_IDLE;
			default: state_d = hkd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != hkd_pkg::ST_IDLE);
		core_start = (state_q == hkd_pkg::ST_HASH);
		result_valid = 1'b0;
		scalar_word = 64'd0;
		scalar_select = 1'b0;
		word_position = 2'd0;
		status = hkd_pkg::STAT_OK;
		last_word = 1'b0;
		case (state_q)
			hkd_pkg::ST_OUT: begin
				result_valid = 1'b1;
				scalar_select = out_cnt_q[2];
				word_position = out_cnt_q[1:0];
				scalar_word = out_cnt_q[2] ? gs_q[64*(2'd3 - out_cnt_q[1:0]) +: 64]
					: ks_q[64*(2'd3 - out_cnt_q[1:0]) +: 64];
				last_word = (out_cnt_q == 3'd7);
			end
			hkd_pkg::ST_ERR: begin
				result_valid = 1'b1;
				status = stat_q;
				last_word = 1'b1;
			end
			default: begin
				result_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hkd_pkg::ST_IDLE;
			step_q <= '0;
			ctr_q <= '0;
			red_cnt_q <= '0;
			out_cnt_q <= '0;
			got_k_q <= 1'b0;
			got_g_q <= 1'b0;
			stat_q <= hkd_pkg::STAT_OK;
			for (int i = 0; i < 4; i++) begin
				seed_q[i] <= 64'd0;
			end
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (wr_index)
					hkd_pkg::REG_SEED0: seed_q[0] <= wr_data;
					hkd_pkg::REG_SEED1: seed_q[1] <= wr_data;
					hkd_pkg::REG_SEED2: seed_q[2] <= wr_data;
					hkd_pkg::REG_SEED3: seed_q[3] <= wr_data;
					default: seed_q[0] <= seed_q[0];
				endcase
			end
			case (state_q)
				hkd_pkg::ST_IDLE: begin
					step_q <= '0;
					ctr_q <= '0;
					red_cnt_q <= '0;
					out_cnt_q <= '0;
					got_k_q <= 1'b0;
					got_g_q <= 1'b0;
					stat_q <= hkd_pkg::STAT_SIGNER;
				end
				hkd_pkg::ST_WAIT: begin
					if (core_done && step_q != hkd_pkg::STEP_T2) begin
						step_q <= step_q + 4'd1;
					end
				end
				hkd_pkg::ST_RED: begin
					red_cnt_q <= red_cnt_q + 3'd1;
					if (red_cnt_q == 3'd3 && nz) begin
						got_k_q <= 1'b1;
					end
					if (red_cnt_q == 3'd7) begin
						if (nz) begin
							got_g_q <= 1'b1;
						end
						ctr_q <= ctr_q + {{(CTR_W-1){1'b0}}, 1'b1};
						step_q <= hkd_pkg::STEP_CTR0;
						stat_q <= hkd_pkg::STAT_LIMIT;
					end
				end
				hkd_pkg::ST_OUT: out_cnt_q <= out_cnt_q + 3'd1;
				default: begin
					step_q <= step_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == hkd_pkg::ST_IDLE && start) begin
			signer_q <= signer_number;
			slot_q <= slot_number;
		end
		if (state_q == hkd_pkg::ST_WAIT && core_done) begin
			if (!step_q[0]) begin
				hash_q <= core_digest;
			end else if (step_q == hkd_pkg::STEP_PRK) begin
				prk_q <= core_digest;
			end else if (step_q == hkd_pkg::STEP_T1) begin
				t1_q <= core_digest;
			end else if (step_q == hkd_pkg::STEP_T2) begin
				t2_q <= core_digest;
			end else begin
				inner_q <= core_digest;
			end
		end
		if (state_q == hkd_pkg::ST_RED) begin
			borrow_q <= bout;
			diff_q <= {d_word, diff_q[255:64]};
			if (red_cnt_q == 3'd3 && !got_k_q) begin
				ks_q <= chosen;
			end
			if (red_cnt_q == 3'd7 && !got_g_q) begin
				gs_q <= chosen;
			end
		end
	end

endmodule

FILE: src/hkd_checker.sv
// port-level checks for the hkdf-sha256 scalar derivation top level
// depends on hkdf_sha256_scalar_nonce_derive_top (bound to it below) and hkd_pkg
module hkd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        result_valid,
	input logic [1:0]  status,
	input logic        last_word
);

	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result transfer while idle");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_word |=> !busy) else $error("busy after last transfer");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != hkd_pkg::STAT_OK |-> last_word)
		else $error("error item not last");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_word |=> result_valid) else $error("gap in result burst");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");

endmodule

bind hkdf_sha256_scalar_nonce_derive_top hkd_checker u_hkd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.status       (status),
	.last_word    (last_word)
);

FILE: sim/tb_hkdf_sha256_scalar_nonce_derive_top.sv
// testbench for hkdf_sha256_scalar_nonce_derive_top: directed table then random requests,
// every result checked against an in-bench hkdf-sha256 scalar derivation
// depends on hkd_pkg and the block rtl
module tb_hkdf_sha256_scalar_nonce_derive_top;

	localparam int MAX_TRIES = 1024;
	localparam logic [255:0] GROUP_ORDER =
		256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;
	localparam logic [143:0] SALT_TEXT = "cggmp21-presign-v1";
	localparam logic [255:0] HASH_IV =
		256'h6a09e667bb67ae853c6ef372a54ff53a510e527f9b05688c1f83d9ab5be0cd19;
	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic [63:0] word;
		logic        sel;
		logic [1:0]  pos;
		logic [1:0]  stat;
		logic        last;
	} scalar_item_t;

	typedef struct {
		logic [31:0] signer;
		logic [31:0] slot;
		logic        typed;
	} request_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] signer_number = '0;
	logic [31:0] slot_number = '0;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = '0;
	logic [63:0] wr_data = '0;
	logic        result_valid;
	logic [63:0] scalar_word;
	logic        scalar_select;
	logic [1:0]  word_position;
	logic [1:0]  status;
	logic        last_word;

	scalar_item_t pending_words[$];
	logic [63:0]  seed_copy [4] = '{default: '0};
	int           fails = 0;
	int           idle_pct = 0;

	hkdf_sha256_scalar_nonce_derive_top #(.MAX_TRIES(MAX_TRIES)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.signer_number(signer_number), .slot_number(slot_number),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.result_valid(result_valid), .scalar_word(scalar_word),
		.scalar_select(scalar_select), .word_position(word_position),
		.status(status), .last_word(last_word)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] le32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic logic [255:0] sha_compress(input logic [255:0] hin,
			input logic [511:0] blk);
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		{a, b, c, d, e, f, g, hh} = hin;
		for (int i = 0; i < 64; i++) begin
			t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[i] + w[i];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		return {a + hin[255:224], b + hin[223:192], c + hin[191:160], d + hin[159:128],
			e + hin[127:96], f + hin[95:64], g + hin[63:32], hh + hin[31:0]};
	endfunction

	// every message here is 65..119 bytes, so always two blocks
	function automatic logic [255:0] sha_two_block(input logic [1023:0] m, input int len);
		logic [1023:0] b;
		b = m;
		for (int i = len; i < 128; i++) b[1023 - 8 * i -: 8] = 8'h00;
		b[1023 - 8 * len -: 8] = 8'h80;
		b[63:0] = 64'(len * 8);
		return sha_compress(sha_compress(HASH_IV, b[1023:512]), b[511:0]);
	endfunction

	function automatic logic [255:0] hmac_sha(input logic [511:0] key,
			input logic [511:0] msg, input int mlen);
		logic [255:0] inner;
		inner = sha_two_block({key ^ {64{8'h36}}, msg}, 64 + mlen);
		return sha_two_block({key ^ {64{8'h5c}}, inner, 256'b0}, 96);
	endfunction

	function automatic logic reduce_half(input logic [255:0] raw, output logic [255:0] v);
		v = (raw >= GROUP_ORDER) ? raw - GROUP_ORDER : raw;
		return v != '0;
	endfunction

	function automatic void derive_scalars(input logic [31:0] signer, input logic [31:0] slot);
		logic [255:0] prk, t1, t2, tmp, ks, gs;
		logic [95:0]  info;
		logic         got_k, got_g;
		int           ctr;
		if (signer == '0) begin
			pending_words.push_back('{64'd0, 1'b0, 2'd0, hkd_pkg::STAT_SIGNER, 1'b1});
			return;
		end
		prk = hmac_sha({SALT_TEXT, 368'b0},
			{seed_copy[0], seed_copy[1], seed_copy[2], seed_copy[3], 256'b0}, 32);
		got_k = 1'b0; got_g = 1'b0; ctr = 0; ks = '0; gs = '0;
		while (!(got_k && got_g)) begin
			info = {le32(signer), le32(slot), le32(32'(ctr))};
			t1 = hmac_sha({prk, 256'b0}, {info, 8'h01, 408'b0}, 13);
			t2 = hmac_sha({prk, 256'b0}, {t1, info, 8'h02, 152'b0}, 45);
			if (!got_k) begin
				got_k = reduce_half(t1, tmp);
				if (got_k) ks = tmp;
			end
			if (!got_g) begin
				got_g = reduce_half(t2, tmp);
				if (got_g) gs = tmp;
			end
			ctr++;
			if (ctr > MAX_TRIES) begin
				pending_words.push_back('{64'd0, 1'b0, 2'd0, hkd_pkg::STAT_LIMIT, 1'b1});
				return;
			end
		end
		for (int i = 0; i < 4; i++)
			pending_words.push_back('{ks[255 - 64 * i -: 64], 1'b0, 2'(i),
				hkd_pkg::STAT_OK, 1'b0});
		for (int i = 0; i < 4; i++)
			pending_words.push_back('{gs[255 - 64 * i -: 64], 1'b1, 2'(i),
				hkd_pkg::STAT_OK, i == 3});
	endfunction

	always @(posedge clk) begin
		scalar_item_t got, want;
		if (arst_n && result_valid) begin
			got = '{scalar_word, scalar_select, word_position, status, last_word};
			if (pending_words.size() == 0) begin
				$display("%0t unexpected result: actual %h %b %0d %0d %b", $time,
					got.word, got.sel, got.pos, got.stat, got.last);
				fails++;
			end else begin
				want = pending_words.pop_front();
				if (got != want) begin
					$display("%0t result mismatch: expected %h %b %0d %0d %b actual %h %b %0d %0d %b",
						$time, want.word, want.sel, want.pos, want.stat, want.last,
						got.word, got.sel, got.pos, got.stat, got.last);
					fails++;
				end
			end
		end
	end

	task automatic send_request(input logic [31:0] signer, input logic [31:0] slot,
			input logic typed);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		signer_number <= signer;
		slot_number <= slot;
		do @(posedge clk); while (busy);
		if (typed)
			pending_words.push_back('{64'd0, 1'b0, 2'd0, hkd_pkg::STAT_SIGNER, 1'b1});
		else
			derive_scalars(signer, slot);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_seed(input logic [63:0] w0, input logic [63:0] w1,
			input logic [63:0] w2, input logic [63:0] w3);
		logic [63:0] vals [4];
		vals = '{w0, w1, w2, w3};
		for (int i = 0; i < 4; i++) begin
			wr_en <= 1'b1;
			wr_index <= 2'(i);
			wr_data <= vals[i];
			seed_copy[i] = vals[i];
			@(posedge clk);
		end
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		request_row_t rows [10];
		int           pcts [4];
		logic [31:0]  signer, slot;
		rows = '{
			'{32'h0, 32'h0, 1'b1},
			'{32'h0, 32'hffffffff, 1'b1},
			'{32'h1, 32'h0, 1'b0},
			'{32'hffffffff, 32'hffffffff, 1'b0},
			'{32'h1, 32'hffffffff, 1'b0},
			'{32'hffffffff, 32'h0, 1'b0},
			'{32'h80000000, 32'h00000001, 1'b0},
			'{32'h55555555, 32'haaaaaaaa, 1'b0},
			'{32'haaaaaaaa, 32'h55555555, 1'b0},
			'{32'h0, 32'h12345678, 1'b1}
		};
		pcts = '{0, 52, 0, 17};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// seed still at its reset value of zero
		foreach (rows[i]) send_request(rows[i].signer, rows[i].slot, rows[i].typed);
		wait_drained();
		load_seed('1, '1, '1, '1);
		send_request(32'h1, 32'h0, 1'b0);
		send_request(32'h0, 32'h0, 1'b1);
		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			case (ph)
				0: load_seed(rand64(), rand64(), rand64(), rand64());
				1: load_seed(64'h8000000000000000, 64'h1, 64'h0, 64'hffffffffffffffff);
				2: load_seed(rand64(), rand64(), rand64(), rand64());
				default: load_seed('0, '0, '0, '0);
			endcase
			idle_pct = pcts[ph];
			for (int n = 0; n < 25; n++) begin
				signer = ($urandom_range(9) == 0) ? 32'h0 : $urandom;
				case ($urandom_range(7))
					0: slot = 32'h0;
					1: slot = 32'hffffffff;
					default: slot = $urandom;
				endcase
				send_request(signer, slot, 1'b0);
			end
		end
		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#40000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
